### hdl/u8lc_pkg.sv
package u8lc_pkg;

    // break_pending codes
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_LF   = 2'd1;
    localparam logic [1:0] PEND_CR   = 2'd2;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_CODE = 8'h80;

    localparam int OUT_WIDTH = 32;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_end;
    } item_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] line_num;
        logic [OUT_WIDTH-1:0] col_num;
        logic [OUT_WIDTH-1:0] char_idx;
        logic [OUT_WIDTH-1:0] byte_pos;
    } result_t;

endpackage

### hdl/u8lc_in_stage.sv
module u8lc_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  u8lc_pkg::item_t s_item,
    output logic           item_valid,
    input  logic           item_take,
    output u8lc_pkg::item_t item
);

    logic            valid_reg;
    u8lc_pkg::item_t item_reg;

    // refill in the same cycle the held item moves on
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

### hdl/u8lc_core.sv
module u8lc_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  u8lc_pkg::item_t   item,
    output u8lc_pkg::result_t result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;

    logic [COUNT_WIDTH-1:0] line_reg,  line_next;
    logic [COUNT_WIDTH-1:0] cil_reg,   cil_next;
    logic [COUNT_WIDTH-1:0] cs_reg,    cs_next;
    logic [COUNT_WIDTH-1:0] bs_reg,    bs_next;
    logic [1:0]             pend_reg,  pend_next;

    logic [COUNT_WIDTH-1:0] line_brk, cil_base;
    logic [COUNT_WIDTH-1:0] o_line, o_col, o_chr, o_off;
    logic                   brk, lead;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [u8lc_pkg::OUT_WIDTH-1:0] clip(
        input logic [COUNT_WIDTH-1:0] v
    );
        logic [63:0] e;
        e = 64'(v);
        clip = (e[63:32] != 32'd0) ? '1 : e[31:0];
    endfunction

    always_comb begin
        brk       = (pend_reg != u8lc_pkg::PEND_NONE) &&
                    !((pend_reg == u8lc_pkg::PEND_CR) &&
                      (item.byte_value == u8lc_pkg::CHAR_LF));
        lead      = (item.byte_value & u8lc_pkg::CONT_MASK) != u8lc_pkg::CONT_CODE;
        line_brk  = brk ? sat_inc(line_reg) : line_reg;
        cil_base  = brk ? CNT_ZERO : cil_reg;

        line_next = line_reg;
        cil_next  = cil_reg;
        cs_next   = cs_reg;
        bs_next   = bs_reg;
        pend_next = pend_reg;
        o_off     = bs_reg;

        if (item.is_end) begin
            if (bs_reg == CNT_ZERO) begin
                o_line = CNT_ONE;
                o_col  = CNT_ZERO;
                o_chr  = CNT_ZERO;
            end else if (pend_reg == u8lc_pkg::PEND_NONE) begin
                o_line = line_reg;
                // one past the last character of the line
                o_col  = (cil_reg != CNT_ZERO) ? cil_reg : CNT_ONE;
                o_chr  = (cil_reg != CNT_ZERO) ? cs_reg  : sat_inc(cs_reg);
            end else begin
                o_line = sat_inc(line_reg);
                o_col  = CNT_ZERO;
                o_chr  = CNT_ZERO;
            end
            line_next = CNT_ONE;
            cil_next  = CNT_ZERO;
            cs_next   = CNT_ZERO;
            bs_next   = CNT_ZERO;
            pend_next = u8lc_pkg::PEND_NONE;
        end else begin
            line_next = line_brk;
            cil_next  = lead ? sat_inc(cil_base) : cil_base;
            cs_next   = lead ? sat_inc(cs_reg)   : cs_reg;
            bs_next   = sat_inc(bs_reg);
            if (item.byte_value == u8lc_pkg::CHAR_LF) begin
                pend_next = u8lc_pkg::PEND_LF;
            end else if (item.byte_value == u8lc_pkg::CHAR_CR) begin
                pend_next = u8lc_pkg::PEND_CR;
            end else begin
                pend_next = u8lc_pkg::PEND_NONE;
            end
            o_line = line_brk;
            o_col  = (cil_next != CNT_ZERO) ? cil_next - CNT_ONE : CNT_ZERO;
            o_chr  = (cil_next != CNT_ZERO) ? cs_next  - CNT_ONE : cs_next;
        end
    end

    assign result.line_num = clip(o_line);
    assign result.col_num  = clip(o_col);
    assign result.char_idx = clip(o_chr);
    assign result.byte_pos = clip(o_off);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= CNT_ONE;
            cil_reg  <= CNT_ZERO;
            cs_reg   <= CNT_ZERO;
            bs_reg   <= CNT_ZERO;
            pend_reg <= u8lc_pkg::PEND_NONE;
        end else if (advance) begin
            line_reg <= line_next;
            cil_reg  <= cil_next;
            cs_reg   <= cs_next;
            bs_reg   <= bs_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### hdl/u8lc_out_stage.sv
module u8lc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  u8lc_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output u8lc_pkg::result_t m_res
);

    logic              valid_reg;
    u8lc_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

### hdl/utf8_line_column_tracker.sv
// The input transfer is registered in the input stage; its position is loaded
// into the result register once that register has room, and then shows on
// m_* until the output transfer takes it.
// Throughput: 1 item per cycle, back to back; a stalled result holds the input.
// Reset (aresetn low, synchronous): both stages empty, line = 1, all other
// counters 0, no break pending. An end item also returns the counters to it.
module utf8_line_column_tracker #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_is_end,
    // position result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_line_num,
    output logic [31:0] m_col_num,
    output logic [31:0] m_char_idx,
    output logic [31:0] m_byte_pos
);

    u8lc_pkg::item_t   s_item;
    u8lc_pkg::item_t   item;
    u8lc_pkg::result_t res;
    u8lc_pkg::result_t m_res;
    logic              item_valid;
    logic              res_ready;
    logic              advance;

    assign s_item.byte_value = s_byte_value;
    assign s_item.is_end     = s_is_end;

    // Stage 1: register the incoming byte.
    u8lc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_take  (advance),
        .item       (item)
    );

    // The held byte is consumed, and the counters step, only when the
    // result register has room for its answer.
    assign advance = item_valid && res_ready;

    // Counter state and position logic; result is combinational from the
    // registered byte and the current counters.
    u8lc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (res)
    );

    // Stage 2: result register, refilled in the cycle it is drained.
    u8lc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_line_num = m_res.line_num;
    assign m_col_num  = m_res.col_num;
    assign m_char_idx = m_res.char_idx;
    assign m_byte_pos = m_res.byte_pos;

endmodule

### hdl/u8lc_checker.sv
module u8lc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_line_num,
    input logic [31:0] m_col_num,
    input logic [31:0] m_char_idx,
    input logic [31:0] m_byte_pos
);

    // pipeline comes out of reset empty and open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("not empty after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_line_num) &&
            $stable(m_col_num) && $stable(m_char_idx) &&
            $stable(m_byte_pos)))
        else $error("stalled result changed");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_num != 32'd0))
        else $error("line number zero");

    a_col_le_chr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_col_num <= m_char_idx))
        else $error("column beyond character index");

    a_chr_le_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_idx <= m_byte_pos))
        else $error("character index beyond byte offset");

endmodule

bind utf8_line_column_tracker u8lc_checker u_u8lc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_line_num (m_line_num),
    .m_col_num  (m_col_num),
    .m_char_idx (m_char_idx),
    .m_byte_pos (m_byte_pos)
);

### verif/utf8_line_column_tracker_tb.sv
`timescale 1ns / 100ps

module utf8_line_column_tracker_tb;

    // Counter width of the block under test; outputs clip to 32 bits.
    localparam int CW = 32;
    // Hard stop.
    localparam int CYCLE_LIMIT = 300000;
    // Percent of cycles in which each side holds off.
    localparam int IDLE_PCT = 36;
    // Window of accepted transfers with no idling on either side.
    localparam int CALM_FIRST = 350;
    localparam int CALM_LAST = 600;
    localparam int RANDOM_ITEMS = 1100;

    // Clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always #2 aclk = ~aclk;

    // DUT ports; the driven inputs are known from time zero
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'h00;
    logic        s_is_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_line_num;
    logic [31:0] m_col_num;
    logic [31:0] m_char_idx;
    logic [31:0] m_byte_pos;

    utf8_line_column_tracker #(
        .COUNT_WIDTH(CW)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_value(s_byte_value),
        .s_is_end    (s_is_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_num  (m_line_num),
        .m_col_num   (m_col_num),
        .m_char_idx  (m_char_idx),
        .m_byte_pos  (m_byte_pos)
    );

    // Bytes waiting to be driven, and positions waiting to come out.
    u8lc_pkg::item_t   pending_bytes[$];
    u8lc_pkg::result_t expected_pos[$];

    // Shadow copy of the tracker state.
    logic [CW-1:0] line_cnt;
    logic [CW-1:0] line_chars;
    logic [CW-1:0] char_cnt;
    logic [CW-1:0] byte_cnt;
    logic [1:0]    brk_state;

    // Bookkeeping
    logic in_taken = 1'b0;   // input transfer at the last rising edge
    int   cycles = 0;
    int   accepted = 0;
    int   n_ends = 0;
    int   n_breaks = 0;
    int   n_conts = 0;
    int   n_checked = 0;
    int   mismatches = 0;
    logic calm;

    assign calm = (accepted >= CALM_FIRST) && (accepted < CALM_LAST);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    function automatic logic [31:0] clip32(input logic [CW-1:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void clear_tracker();
        line_cnt   = CW'(1);
        line_chars = '0;
        char_cnt   = '0;
        byte_cnt   = '0;
        brk_state  = u8lc_pkg::PEND_NONE;
    endfunction

    // Position of one byte (or of the past-the-end point), with state update.
    function automatic u8lc_pkg::result_t track_position(input logic [7:0] b,
                                                         input logic is_end);
        u8lc_pkg::result_t r;
        logic [CW-1:0] col;
        logic [CW-1:0] chr;
        // column/char of the lead byte currently owning the line position
        col = (line_chars != '0) ? line_chars - CW'(1) : '0;
        chr = (line_chars != '0) ? char_cnt - CW'(1) : char_cnt;
        if (is_end) begin
            if (byte_cnt == '0) begin
                // empty content
                r.line_num = 32'd1;
                r.col_num  = 32'd0;
                r.char_idx = 32'd0;
                r.byte_pos = 32'd0;
            end else if (brk_state == u8lc_pkg::PEND_NONE) begin
                // last line has characters: one past the last one
                r.line_num = clip32(line_cnt);
                r.col_num  = clip32(sat_inc(col));
                r.char_idx = clip32(sat_inc(chr));
                r.byte_pos = clip32(byte_cnt);
            end else begin
                // content ends in a break: start of the next line
                r.line_num = clip32(sat_inc(line_cnt));
                r.col_num  = 32'd0;
                r.char_idx = 32'd0;
                r.byte_pos = clip32(byte_cnt);
            end
            clear_tracker();
            return r;
        end

        // a pending break takes effect, except CR directly followed by LF
        if (brk_state != u8lc_pkg::PEND_NONE &&
            !(brk_state == u8lc_pkg::PEND_CR && b == u8lc_pkg::CHAR_LF)) begin
            line_cnt   = sat_inc(line_cnt);
            line_chars = '0;
        end

        if (b == u8lc_pkg::CHAR_LF)
            brk_state = u8lc_pkg::PEND_LF;
        else if (b == u8lc_pkg::CHAR_CR)
            brk_state = u8lc_pkg::PEND_CR;
        else
            brk_state = u8lc_pkg::PEND_NONE;

        // only lead bytes advance the code-point counters
        if ((b & u8lc_pkg::CONT_MASK) != u8lc_pkg::CONT_CODE) begin
            line_chars = sat_inc(line_chars);
            char_cnt   = sat_inc(char_cnt);
        end

        col = (line_chars != '0) ? line_chars - CW'(1) : '0;
        chr = (line_chars != '0) ? char_cnt - CW'(1) : char_cnt;
        r.line_num = clip32(line_cnt);
        r.col_num  = clip32(col);
        r.char_idx = clip32(chr);
        r.byte_pos = clip32(byte_cnt);
        byte_cnt = sat_inc(byte_cnt);
        return r;
    endfunction

    // Stimulus helpers
    task automatic queue_item(input u8lc_pkg::item_t it);
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    task automatic push_byte(input logic [7:0] b);
        u8lc_pkg::item_t it;
        it.byte_value = b;
        it.is_end     = 1'b0;
        queue_item(it);
    endtask

    task automatic push_end();
        u8lc_pkg::item_t it;
        // payload byte is don't-care on an end transfer; keep it random
        it.byte_value = 8'($urandom_range(0, 255));
        it.is_end     = 1'b1;
        queue_item(it);
    endtask

    function automatic logic [7:0] cont_byte();
        return u8lc_pkg::CONT_CODE | 8'($urandom_range(0, 63));
    endfunction

    // One code point: a lead byte and its continuations, 1 to 4 bytes.
    task automatic push_char();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            push_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 7) begin
            push_byte(8'($urandom_range(8'hC2, 8'hDF)));
            push_byte(cont_byte());
        end else if (kind < 9) begin
            push_byte(8'($urandom_range(8'hE0, 8'hEF)));
            push_byte(cont_byte());
            push_byte(cont_byte());
        end else begin
            push_byte(8'($urandom_range(8'hF0, 8'hF7)));
            push_byte(cont_byte());
            push_byte(cont_byte());
            push_byte(cont_byte());
        end
    endtask

    // Line terminator: LF, CR, CR+LF or a doubled CR.
    task automatic push_break();
        case ($urandom_range(0, 3))
            0: begin
                push_byte(u8lc_pkg::CHAR_LF);
            end
            1: begin
                push_byte(u8lc_pkg::CHAR_CR);
            end
            2: begin
                push_byte(u8lc_pkg::CHAR_CR);
                push_byte(u8lc_pkg::CHAR_LF);
            end
            default: begin
                push_byte(u8lc_pkg::CHAR_CR);
                push_byte(u8lc_pkg::CHAR_CR);
            end
        endcase
    endtask

    // A short text of random lines, closed by an end transfer.
    task automatic push_text();
        int n_lines;
        int n_chars;
        n_lines = $urandom_range(0, 4);
        for (int l = 0; l < n_lines; l++) begin
            n_chars = $urandom_range(0, 8);
            for (int c = 0; c < n_chars; c++)
                push_char();
            // last line may or may not be terminated
            if (l < n_lines - 1 || $urandom_range(0, 1))
                push_break();
        end
        push_end();
    endtask

    // Raw bytes, including stray continuations and bare breaks.
    task automatic push_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) != 0)
            push_end();
    endtask

    // Driver: new payload on the falling edge once the previous one is taken.
    always @(negedge aclk) begin
        u8lc_pkg::item_t nxt;
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_bytes.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pending_bytes.pop_front();
                    s_byte_value <= nxt.byte_value;
                    s_is_end     <= nxt.is_end;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Input capture and result check share one block, so a prediction made
    // at an edge is always queued before any result is popped at that edge.
    always @(posedge aclk) begin
        u8lc_pkg::result_t want;
        u8lc_pkg::result_t got;
        logic              bad;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expected_pos.insert(expected_pos.size(),
                                    track_position(s_byte_value, s_is_end));
                accepted <= accepted + 1;
                if (s_is_end)
                    n_ends <= n_ends + 1;
                else if (s_byte_value == u8lc_pkg::CHAR_LF ||
                         s_byte_value == u8lc_pkg::CHAR_CR)
                    n_breaks <= n_breaks + 1;
                else if ((s_byte_value & u8lc_pkg::CONT_MASK) == u8lc_pkg::CONT_CODE)
                    n_conts <= n_conts + 1;
            end
            if (m_valid && m_ready) begin
                got.line_num = m_line_num;
                got.col_num  = m_col_num;
                got.char_idx = m_char_idx;
                got.byte_pos = m_byte_pos;
                if (expected_pos.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("[%0t] unexpected result line=%0d col=%0d char=%0d off=%0d",
                                 $realtime, got.line_num, got.col_num,
                                 got.char_idx, got.byte_pos);
                end else begin
                    want = expected_pos.pop_front();
                    n_checked <= n_checked + 1;
                    bad = (got.line_num !== want.line_num) ||
                          (got.col_num !== want.col_num) ||
                          (got.char_idx !== want.char_idx) ||
                          (got.byte_pos !== want.byte_pos);
                    if (bad) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"[%0t] mismatch #%0d: line %0d/%0d col %0d/%0d ",
                                      "char %0d/%0d off %0d/%0d (exp/act)"},
                                     $realtime, n_checked,
                                     want.line_num, got.line_num,
                                     want.col_num, got.col_num,
                                     want.char_idx, got.char_idx,
                                     want.byte_pos, got.byte_pos);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, expected_pos.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        clear_tracker();

        // Directed texts
        // empty content; end payload byte set to ignore it
        queue_item('{byte_value: 8'hFF, is_end: 1'b1});
        // continuation as very first byte, then a char, trailing characters
        push_byte(8'h80);
        push_byte(8'h41);
        push_end();
        // CR+LF as one break, bare CR as a break, trailing char
        push_byte(u8lc_pkg::CHAR_CR);
        push_byte(u8lc_pkg::CHAR_LF);
        push_byte(u8lc_pkg::CHAR_CR);
        push_byte(8'h58);
        push_end();
        // 3-byte code point, LF, continuation at line start, trailing CR
        push_byte(8'hE2);
        push_byte(8'h82);
        push_byte(8'hAC);
        push_byte(u8lc_pkg::CHAR_LF);
        push_byte(8'hBF);
        push_byte(u8lc_pkg::CHAR_CR);
        push_end();
        // byte extremes, trailing LF
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(u8lc_pkg::CHAR_LF);
        push_end();
        // two CRs are two breaks
        push_byte(u8lc_pkg::CHAR_CR);
        push_byte(u8lc_pkg::CHAR_CR);
        push_end();

        // Random part: mostly well-formed texts, some raw noise
        while (pending_bytes.size() < RANDOM_ITEMS + 23) begin
            if ($urandom_range(0, 9) < 8)
                push_text();
            else
                push_noise();
        end
        push_end();

        // Reset, released on a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: everything sent and every position returned
        while (pending_bytes.size() != 0 || s_valid || expected_pos.size() != 0)
            @(negedge aclk);
        // idle on to catch stray results
        repeat (10) @(negedge aclk);

        $display("%0d transfers in (%0d ends, %0d line-break bytes, %0d continuation bytes),",
                 accepted, n_ends, n_breaks, n_conts);
        $display("%0d positions checked, %0d mismatches, %0d cycles",
                 n_checked, mismatches, cycles);
        if (mismatches == 0 && expected_pos.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
